/* sv/icdc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// icdc_pkg
// Shared types and constants for the task class decay classifier.
// ----------------------------------------------------------------------------
package icdc_pkg;

	// default sizing
	localparam int TASK_COUNT_DEF    = 256;
	localparam int COUNTER_WIDTH_DEF = 16;

	// config register widths, indexes and reset values
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] CFG_PRIO_THR  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DECAY_LIM = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_SAMP  = 2'd2;
	localparam logic [7:0]  PRIO_THR_RST  = 8'd50;
	localparam logic [15:0] DECAY_LIM_RST = 16'd256;
	localparam logic [14:0] MIN_SAMP_RST  = 15'd8;

	// hardware class codes
	localparam logic [7:0] HW_SCALAR = 8'd0;
	localparam logic [7:0] HW_VECTOR = 8'd1;
	localparam logic [7:0] HW_VNNI   = 8'd2;
	localparam logic [7:0] HW_SPIN   = 8'd3;

	// stored task class codes
	localparam logic [1:0] CLS_NONE = 2'd0;
	localparam logic [1:0] CLS_E    = 2'd1;
	localparam logic [1:0] CLS_P    = 2'd2;

	// input item
	typedef struct packed {
		logic [7:0] task_index;
		logic       read_ok;
		logic [7:0] hw_class;
		logic [7:0] cpu_priority;
		logic       siblings_idle;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [1:0] task_class;
		logic       class_written;
	} out_item_t;

	// controller states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COMMIT
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic commit;
		logic clear_we;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_busy;
	} status_t;

endpackage
`default_nettype wire

/* sv/icdc_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// icdc_store
// Per-task entry memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module icdc_store #(
	parameter int DEPTH  = icdc_pkg::TASK_COUNT_DEF,
	parameter int WIDTH  = 3 * icdc_pkg::COUNTER_WIDTH_DEF + 2,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* sv/icdc_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// icdc_ctrl
// Sequencer: clearing pass after reset, item accept, then commit of the
// updated entry and result.
// ----------------------------------------------------------------------------
module icdc_ctrl #(
	parameter int TASK_COUNT = icdc_pkg::TASK_COUNT_DEF,
	parameter int ADDR_W     = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire icdc_pkg::status_t status,
	output icdc_pkg::cmd_t         cmd,
	output logic      [ADDR_W-1:0] clr_addr_q
);

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TASK_COUNT - 1);

	icdc_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= icdc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (state_q == icdc_pkg::ST_CLEAR) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		in_stall     = 1'b1;
		unique case (state_q)
			icdc_pkg::ST_CLEAR: begin
				cmd.clear_we = 1'b1;
				if (clr_addr_q == LAST_ADDR) begin
					state_d = icdc_pkg::ST_IDLE;
				end
			end
			icdc_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = icdc_pkg::ST_COMMIT;
				end
			end
			icdc_pkg::ST_COMMIT: begin
				// wait for the output register to free up
				if (!status.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = icdc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = icdc_pkg::ST_CLEAR;
			end
		endcase
	end

endmodule
`default_nettype wire

/* sv/icdc_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// icdc_datapath
// Config registers, item register, entry update (weighting, saturation,
// decay, classification), entry store and output register.
// ----------------------------------------------------------------------------
module icdc_datapath #(
	parameter int TASK_COUNT    = icdc_pkg::TASK_COUNT_DEF,
	parameter int COUNTER_WIDTH = icdc_pkg::COUNTER_WIDTH_DEF,
	parameter int ADDR_W        = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [icdc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [icdc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire icdc_pkg::in_item_t                 in_data,
	input  wire icdc_pkg::cmd_t                     cmd,
	input  wire logic [ADDR_W-1:0]                  clr_addr,
	output icdc_pkg::status_t                       status,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output icdc_pkg::out_item_t                     out_data
);

	localparam int CW      = COUNTER_WIDTH;
	localparam int ENTRY_W = 3 * CW + 2;
	localparam int PW      = CW + 3;

	// config registers
	logic [7:0]  prio_thr_q;
	logic [15:0] decay_lim_q;
	logic [14:0] min_samp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_thr_q  <= icdc_pkg::PRIO_THR_RST;
			decay_lim_q <= icdc_pkg::DECAY_LIM_RST;
			min_samp_q  <= icdc_pkg::MIN_SAMP_RST;
		end else if (cfg_we) begin
			if (cfg_index == icdc_pkg::CFG_PRIO_THR) begin
				prio_thr_q <= cfg_data[7:0];
			end
			if (cfg_index == icdc_pkg::CFG_DECAY_LIM) begin
				decay_lim_q <= cfg_data;
			end
			if (cfg_index == icdc_pkg::CFG_MIN_SAMP) begin
				min_samp_q <= cfg_data[14:0];
			end
		end
	end

	// item register, loaded on accept
	icdc_pkg::in_item_t item_s1;
	logic               in_range_s1;
	logic [ADDR_W-1:0]  rd_addr;
	logic               in_range;

	assign rd_addr  = ADDR_W'(in_data.task_index);
	assign in_range = (32'(in_data.task_index) < TASK_COUNT);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_s1     <= in_data;
			in_range_s1 <= in_range;
		end
	end

	// entry store
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic [ENTRY_W-1:0] entry_q;

	icdc_store #(
		.DEPTH  (TASK_COUNT),
		.WIDTH  (ENTRY_W),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (cmd.accept),
		.raddr   (rd_addr),
		.rdata_q (entry_q)
	);

	// unpack stored entry
	logic [1:0]    cls_old;
	logic [CW-1:0] tot_old, p_old, e_old;

	assign {cls_old, tot_old, p_old, e_old} = entry_q;

	// sample filter
	logic is_vnni, is_spin, take;

	assign is_vnni = (item_s1.hw_class == icdc_pkg::HW_VNNI);
	assign is_spin = (item_s1.hw_class == icdc_pkg::HW_SPIN);
	assign take    = item_s1.read_ok && (item_s1.cpu_priority > prio_thr_q)
	                 && (item_s1.siblings_idle || is_vnni || is_spin);

	// per-class weights
	logic [1:0] e_inc, p_inc, t_inc;

	always_comb begin
		e_inc = 2'd0;
		p_inc = 2'd0;
		if (item_s1.hw_class == icdc_pkg::HW_SCALAR) begin
			e_inc = 2'd1;
		end
		if (item_s1.hw_class == icdc_pkg::HW_VECTOR) begin
			p_inc = 2'd1;
		end
		if (is_vnni) begin
			p_inc = 2'd2;
		end
		if (is_spin) begin
			e_inc = 2'd2;
		end
		t_inc = e_inc | p_inc;
	end

	// saturating adds
	logic [CW:0]   e_sum, p_sum, t_sum;
	logic [CW-1:0] e_add, p_add, t_add;

	assign e_sum = {1'b0, e_old} + (CW + 1)'(e_inc);
	assign p_sum = {1'b0, p_old} + (CW + 1)'(p_inc);
	assign t_sum = {1'b0, tot_old} + (CW + 1)'(t_inc);
	assign e_add = e_sum[CW] ? '1 : e_sum[CW-1:0];
	assign p_add = p_sum[CW] ? '1 : p_sum[CW-1:0];
	assign t_add = t_sum[CW] ? '1 : t_sum[CW-1:0];

	// decay: halve all counters once the total reaches the limit
	logic          decay;
	logic [CW-1:0] e_new, p_new, t_new;

	assign decay = (32'(t_add) >= 32'(decay_lim_q));
	assign e_new = decay ? (e_add >> 1) : e_add;
	assign p_new = decay ? (p_add >> 1) : p_add;
	assign t_new = decay ? (t_add >> 1) : t_add;

	// classification: P when 5*P exceeds 2*total
	logic          enough;
	logic [PW-1:0] p_x5, t_x2;
	logic [1:0]    cls_new;

	assign enough  = (32'(t_new) >= 32'(min_samp_q));
	assign p_x5    = (PW'(p_new) << 2) + PW'(p_new);
	assign t_x2    = PW'(t_new) << 1;
	assign cls_new = (p_x5 > t_x2) ? icdc_pkg::CLS_P : icdc_pkg::CLS_E;

	logic       upd, written;
	logic [1:0] cls_wb;

	// a dropped sample keeps the stored class
	assign upd     = in_range_s1 && take;
	assign written = upd && enough;
	assign cls_wb  = written ? cls_new : cls_old;

	// store write: clearing sweep or entry update
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_addr;
		mem_wdata = '0;
		if (cmd.clear_we) begin
			mem_we = 1'b1;
		end else if (cmd.commit && upd) begin
			mem_we    = 1'b1;
			mem_waddr = ADDR_W'(item_s1.task_index);
			mem_wdata = {cls_wb, t_new, p_new, e_new};
		end
	end

	// output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_data.task_class    <= in_range_s1 ? cls_wb : icdc_pkg::CLS_NONE;
			out_data.class_written <= written;
		end
	end

	assign out_valid       = out_valid_q;
	assign status.out_busy = out_valid_q && out_stall;

endmodule
`default_nettype wire

/* sv/ipc_class_decay_classifier_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ipc_class_decay_classifier_core
// Per-task class decay classifier, top level.
//
// Input channel in_valid/in_stall/in_data carries one tick sample per item;
// output channel out_valid/out_stall/out_data returns one result per item.
// Configuration registers are to be written through cfg_we/cfg_index/cfg_data
// only while the block is idle; the user must keep to this, as the block
// itself does not enforce it. Index 0 priority threshold, 1 decay limit,
// 2 minimum samples. The accept edge reads the task entry from the
// single-port-write entry memory; once the output register is free, the
// commit step writes the updated entry back and loads the output register.
// No new item is taken until the current one has been committed.
// After reset the block sweeps the entry memory to zero, one entry per
// cycle, with in_stall high; config writes are taken.
// While out_stall holds a result, the block still accepts one more item
// and then holds it in the commit step until the output register frees.
// ----------------------------------------------------------------------------
module ipc_class_decay_classifier_core #(
	parameter int TASK_COUNT    = icdc_pkg::TASK_COUNT_DEF,
	parameter int COUNTER_WIDTH = icdc_pkg::COUNTER_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [icdc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [icdc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire icdc_pkg::in_item_t                in_data,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output icdc_pkg::out_item_t                    out_data
);

	localparam int ADDR_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

	icdc_pkg::cmd_t    cmd;
	icdc_pkg::status_t status;
	logic [ADDR_W-1:0] clr_addr;

	// sequencer
	icdc_ctrl #(
		.TASK_COUNT (TASK_COUNT),
		.ADDR_W     (ADDR_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.status     (status),
		.cmd        (cmd),
		.clr_addr_q (clr_addr)
	);

	// datapath and entry store
	icdc_datapath #(
		.TASK_COUNT    (TASK_COUNT),
		.COUNTER_WIDTH (COUNTER_WIDTH),
		.ADDR_W        (ADDR_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.clr_addr  (clr_addr),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire
